// File: sv/rgbdbp_pkg.sv
// shared types and constants for the masked rgb-d back-projection block
// used by rgbdbp_div and rgbd_masked_backprojection; no dependencies
package rgbdbp_pkg;

    localparam int MAX_REGIONS_DEF = 8;

    // configuration port
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAR      = 3'd5;

    localparam logic [CFG_W-1:0] FOCAL_X_RST  = 16'd8000;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 16'd8000;
    localparam logic [CFG_W-1:0] CENTER_X_RST = 16'd5120;
    localparam logic [CFG_W-1:0] CENTER_Y_RST = 16'd3840;
    localparam logic [CFG_W-1:0] NEAR_RST     = 16'd300;
    localparam logic [CFG_W-1:0] FAR_RST      = 16'd5000;

    // item kinds on the input tuser
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REGION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd2;

    localparam int RECT_W  = 13;
    localparam int PIX_W   = 12;
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;
    localparam int COORD_W = 24;

    localparam logic [RECT_W-1:0] SMALL_SIDE = 13'd2;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 88;

    // divider: 32-bit magnitude over 16-bit focal, 24 quotient bits
    localparam int PROD_W      = 32;
    localparam int DIVR_W      = 16;
    localparam int QUOT_W      = 24;
    localparam int DIV_BITS    = 2;
    localparam int DIV_CYCLES  = QUOT_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);

    typedef struct packed {
        logic signed [RECT_W-1:0] left;
        logic signed [RECT_W-1:0] top;
        logic [RECT_W-1:0]        width;
        logic [RECT_W-1:0]        height;
    } t_rect;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

// File: sv/rgbd_masked_backprojection.sv
// masked rgb-d back-projection: pixels to camera-frame colored points
// depends on rgbdbp_pkg and rgbdbp_div
//
//  channel   direction  handshake                  payload
//  s_axis    in         tvalid / tready            tdata (pixel, region), tuser (kind)
//  m_axis    out        tvalid / tready            tdata (point), tuser (saturated)
//  cfg       in         we, no wait                addr, wdata
//
// a pixel that passes all tests is checked against the n regions stored; one
// 16x16 multiplier and one divider (12 iterations per coordinate) are
// shared by x and y.
// a dropped pixel leaves at acceptance or during the region scan; frame and region items are handled in idle.
// s_axis is ready only while the sequencer is idle; a finished point sits in the
// output register so the next item can be taken while m_axis is stalled.
// reset is synchronous, active low; the region store itself is not cleared.
module rgbd_masked_backprojection #(
    parameter int MAX_REGIONS = rgbdbp_pkg::MAX_REGIONS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // rect_left, rect_top, rect_width, rect_height, col, row, depth_mm,
    // blue, green, red, 4 zero bits
    input  logic [rgbdbp_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // kind
    input  logic [rgbdbp_pkg::KIND_W-1:0]         i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // point_x, point_y, point_z, out_blue, out_green, out_red
    output logic [rgbdbp_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // saturated
    output logic [0:0]                            o_m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [rgbdbp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rgbdbp_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import rgbdbp_pkg::*;

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CMP_W = RECT_W + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MUL_X = 3'd2;
    localparam logic [2:0] S_DIV_X = 3'd3;
    localparam logic [2:0] S_MUL_Y = 3'd4;
    localparam logic [2:0] S_DIV_Y = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // input fields
    logic [KIND_W-1:0]  in_kind;
    t_rect              in_rect;
    logic [PIX_W-1:0]   in_col, in_row;
    logic [DEPTH_W-1:0] in_depth;
    logic [COLOR_W-1:0] in_blue, in_green, in_red;

    assign in_kind        = i_s_axis_tuser;
    assign in_rect.left   = i_s_axis_tdata[12:0];
    assign in_rect.top    = i_s_axis_tdata[25:13];
    assign in_rect.width  = i_s_axis_tdata[38:26];
    assign in_rect.height = i_s_axis_tdata[51:39];
    assign in_col         = i_s_axis_tdata[63:52];
    assign in_row         = i_s_axis_tdata[75:64];
    assign in_depth       = i_s_axis_tdata[91:76];
    assign in_blue        = i_s_axis_tdata[99:92];
    assign in_green       = i_s_axis_tdata[107:100];
    assign in_red         = i_s_axis_tdata[115:108];

    // configuration registers
    logic [CFG_W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y, r_near, r_far;

    // control
    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic             r_first_small;
    logic             r_seen;
    logic             r_div_start;
    logic             r_out_valid;

    // payload
    t_rect              r_store [MAX_REGIONS];
    logic [PIX_W-1:0]   r_col, r_row;
    logic [DEPTH_W-1:0] r_depth;
    logic [COLOR_W-1:0] r_blue, r_green, r_red;
    logic [PROD_W-1:0]  r_prod;
    logic               r_neg;
    logic [COORD_W-1:0] r_px, r_py;
    logic               r_sat_x, r_sat_y;
    logic [COORD_W-1:0] r_o_x, r_o_y;
    logic [DEPTH_W-1:0] r_o_z;
    logic [COLOR_W-1:0] r_o_blue, r_o_green, r_o_red;
    logic               r_o_sat;

    logic accept;
    logic emit_fire;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    // finished point moves into the output register
    assign emit_fire       = (r_state == S_EMIT) && (!r_out_valid || i_m_axis_tready);

    // frame classification
    logic             store_full, region_small, first_small_new, dyn_new, pix_dyn, depth_ok;
    logic [CNT_W-1:0] count_new;

    always_comb begin
        store_full      = (r_count == CNT_W'(MAX_REGIONS));
        region_small    = (in_rect.width <= SMALL_SIDE) && (in_rect.height <= SMALL_SIDE);
        first_small_new = (r_count == '0) ? region_small : r_first_small;
        count_new       = store_full ? r_count : r_count + CNT_W'(1);
        dyn_new         = (count_new > CNT_W'(1)) || !first_small_new;
        pix_dyn         = (r_count > CNT_W'(1)) || ((r_count == CNT_W'(1)) && !r_first_small);
        depth_ok        = (in_depth >= r_near) && (in_depth <= r_far);
    end

    // containment test of one stored rectangle per cycle
    t_rect                   cur;
    logic signed [CMP_W-1:0] c_s, row_s, left_s, top_s, right_s, bottom_s;
    logic                    hit, scan_last;

    always_comb begin
        cur      = r_store[r_idx];
        c_s      = signed'({3'b000, r_col});
        row_s    = signed'({3'b000, r_row});
        left_s   = signed'({{2{cur.left[RECT_W-1]}}, cur.left});
        top_s    = signed'({{2{cur.top[RECT_W-1]}}, cur.top});
        right_s  = left_s + signed'({2'b00, cur.width});
        bottom_s = top_s + signed'({2'b00, cur.height});
        hit      = (c_s >= left_s) && (c_s < right_s) && (row_s >= top_s) &&
                   (row_s < bottom_s);
        scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    end

    // shared multiplier: |16*pix - center| * depth
    logic              sel_y, diff_neg;
    logic [CFG_W-1:0]  pix16, ctr, diff_mag;
    logic [PROD_W-1:0] prod;

    always_comb begin
        sel_y    = (r_state == S_MUL_Y);
        pix16    = sel_y ? {r_row, 4'b0000} : {r_col, 4'b0000};
        ctr      = sel_y ? r_center_y : r_center_x;
        diff_neg = (pix16 < ctr);
        diff_mag = diff_neg ? (ctr - pix16) : (pix16 - ctr);
        prod     = PROD_W'(diff_mag) * PROD_W'(r_depth);
    end

    // shared divider
    t_div_req div_req;
    t_div_res div_res;

    always_comb begin
        div_req.start    = r_div_start;
        div_req.dividend = r_prod;
        div_req.divisor  = (r_state == S_DIV_Y) ? r_focal_y : r_focal_x;
    end

    rgbdbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    // sign, truncation and saturation of a quotient
    logic [COORD_W-1:0] coord_val;
    logic               coord_sat;

    always_comb begin
        coord_val = div_res.quot;
        coord_sat = 1'b0;
        if (r_prod == '0) begin
            // covers zero focal with zero numerator
            coord_val = '0;
        end else if (!r_neg) begin
            if (div_res.ovf || div_res.quot[QUOT_W-1]) begin
                coord_sat = 1'b1;
                coord_val = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end else begin
            if (div_res.ovf || (div_res.quot[QUOT_W-1] && (div_res.quot[QUOT_W-2:0] != '0))) begin
                coord_sat = 1'b1;
                coord_val = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                coord_val = -div_res.quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= FOCAL_X_RST;
            r_focal_y  <= FOCAL_Y_RST;
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
            r_near     <= NEAR_RST;
            r_far      <= FAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_wdata;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_wdata;
                CFG_CENTER_X: r_center_x <= i_cfg_wdata;
                CFG_CENTER_Y: r_center_y <= i_cfg_wdata;
                CFG_NEAR:     r_near     <= i_cfg_wdata;
                CFG_FAR:      r_far      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_idx         <= '0;
            r_first_small <= 1'b0;
            r_seen        <= 1'b0;
            r_div_start   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_MUL_X) || (r_state == S_MUL_Y);
            r_out_valid <= emit_fire || (r_out_valid && !i_m_axis_tready);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (in_kind)
                            KIND_FRAME: begin
                                r_count <= '0;
                            end
                            KIND_REGION: begin
                                r_count       <= count_new;
                                r_first_small <= first_small_new;
                                if (dyn_new) begin
                                    r_seen <= 1'b1;
                                end
                            end
                            KIND_PIXEL: begin
                                if (pix_dyn) begin
                                    r_seen <= 1'b1;
                                end
                                // static frame after a dynamic one drops the pixel
                                if ((pix_dyn || !r_seen) && depth_ok) begin
                                    r_idx   <= '0;
                                    r_state <= (r_count == '0) ? S_MUL_X : S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_state <= S_IDLE;
                    end else if (scan_last) begin
                        r_state <= S_MUL_X;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_MUL_X: begin
                    r_state <= S_DIV_X;
                end
                S_DIV_X: begin
                    if (div_res.done) begin
                        r_state <= S_MUL_Y;
                    end
                end
                S_MUL_Y: begin
                    r_state <= S_DIV_Y;
                end
                S_DIV_Y: begin
                    if (div_res.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (in_kind == KIND_REGION) && !store_full) begin
            r_store[r_count[IDX_W-1:0]] <= in_rect;
        end
        if (accept && (in_kind == KIND_PIXEL)) begin
            r_col   <= in_col;
            r_row   <= in_row;
            r_depth <= in_depth;
            r_blue  <= in_blue;
            r_green <= in_green;
            r_red   <= in_red;
        end
        if ((r_state == S_MUL_X) || (r_state == S_MUL_Y)) begin
            r_prod <= prod;
            r_neg  <= diff_neg;
        end
        if ((r_state == S_DIV_X) && div_res.done) begin
            r_px    <= coord_val;
            r_sat_x <= coord_sat;
        end
        if ((r_state == S_DIV_Y) && div_res.done) begin
            r_py    <= coord_val;
            r_sat_y <= coord_sat;
        end
        if (emit_fire) begin
            r_o_x     <= r_px;
            r_o_y     <= r_py;
            r_o_z     <= r_depth;
            r_o_blue  <= r_blue;
            r_o_green <= r_green;
            r_o_red   <= r_red;
            r_o_sat   <= r_sat_x || r_sat_y;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_o_red, r_o_green, r_o_blue, r_o_z, r_o_y, r_o_x};
    assign o_m_axis_tuser  = r_o_sat;

endmodule

// File: sv/rgbdbp_div.sv
// iterative unsigned divider, two quotient bits per cycle
// depends on rgbdbp_pkg; flags overflow when the quotient needs more than QUOT_W bits
module rgbdbp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgbdbp_pkg::t_div_req i_req,
    output rgbdbp_pkg::t_div_res o_res
);
    import rgbdbp_pkg::*;

    localparam int HEAD_W = PROD_W - QUOT_W;

    logic [DIVR_W:0]    r_rem, n_rem;
    logic [QUOT_W-1:0]  r_low, n_low;
    logic [QUOT_W-1:0]  r_q, n_q;
    logic [DIVR_W-1:0]  r_divisor;
    logic               r_ovf;
    logic               r_busy;
    logic               r_done;
    logic [DIV_CNT_W-1:0] r_cnt;

    always_comb begin
        n_rem = r_rem;
        n_low = r_low;
        n_q   = r_q;
        for (int k = 0; k < DIV_BITS; k++) begin
            n_rem = {n_rem[DIVR_W-1:0], n_low[QUOT_W-1]};
            n_low = {n_low[QUOT_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_divisor}) begin
                n_rem = n_rem - {1'b0, r_divisor};
                n_q   = {n_q[QUOT_W-2:0], 1'b1};
            end else begin
                n_q   = {n_q[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_CYCLES);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // top bits form the first partial remainder; if they reach the
            // divisor the quotient cannot fit
            r_rem     <= {{(DIVR_W + 1 - HEAD_W){1'b0}}, i_req.dividend[PROD_W-1:QUOT_W]};
            r_ovf     <= DIVR_W'(i_req.dividend[PROD_W-1:QUOT_W]) >= i_req.divisor;
            r_low     <= i_req.dividend[QUOT_W-1:0];
            r_q       <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_q   <= n_q;
        end
    end

    always_comb begin
        o_res.done = r_done;
        o_res.ovf  = r_ovf;
        o_res.quot = r_q;
    end

endmodule
